// ----- hw/rtl/tcw_pkg.sv -----
`default_nettype none

package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int MODE_W = 2;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Register map
    localparam logic [0:0]        REG_TEXT_ATTR = 1'b0;
    localparam logic [ATTR_W-1:0] ATTR_RESET    = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_RESET   = {ATTR_RESET, CH_SPACE};

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NOP,
        OP_PRINT,
        OP_BS,
        OP_TAB,
        OP_CR,
        OP_LF,
        OP_CLEAR,
        OP_READ
    } t_op_kind;

    typedef struct packed {
        t_op_kind          kind;
        logic [CHAR_W-1:0] char_code;
        logic [ADDR_W-1:0] cell_index;
    } t_op;

    typedef struct packed {
        logic sweeping;
    } t_back_stat;

    // Linear cell address of a row/column pair
    function automatic logic [ADDR_W-1:0] cell_loc(logic [ROW_W-1:0] row,
                                                   logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/text_console_writer_top.sv -----
`default_nettype none

// Text console engine over an 80x25 store of 16-bit cells (attribute byte
// high, character low) with a cursor. A request is taken when start is high
// and busy is low; each request gives exactly one result, shown for a single
// cycle with o_result_valid, and the receiver cannot hold it off. Requests go
// through a two-entry queue, so up to two may be waiting behind the engine.
// Cursor-only ops and printable characters pass the queue and the registered
// result stage, and run back to back at one per cycle while no clear, read or
// scroll holds the engine. A cell read also waits in S_READ for the registered
// store read. Clear writes every cell, one per cycle. A scroll copies 1920
// cells through the store's one read port and one write port and then blanks
// the bottom line, after which the character's result comes out. After reset
// the store is blanked to 0x0F20 while busy stays high; register writes are
// still taken during that time.
module text_console_writer_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [tcw_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  wire logic [tcw_pkg::ADDR_W-1:0]  i_cell_index,
    output logic                             o_result_valid,
    output logic      [tcw_pkg::COL_W-1:0]   o_cursor_col,
    output logic      [tcw_pkg::ROW_W-1:0]   o_cursor_row,
    output logic      [tcw_pkg::ADDR_W-1:0]  o_cursor_location,
    output logic      [tcw_pkg::CELL_W-1:0]  o_cell_value,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import tcw_pkg::*;

    logic              push;
    t_op               push_op;
    logic              q_full;
    logic              q_valid;
    t_op               q_op;
    logic              q_pop;
    t_back_stat        back_stat;
    logic [ATTR_W-1:0] attr;

    tcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_q_full     (q_full),
        .i_back_stat  (back_stat),
        .o_push       (push),
        .o_op         (push_op),
        .o_attr       (attr)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op),
        .o_full  (q_full)
    );

    tcw_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_attr            (attr),
        .i_q_valid         (q_valid),
        .i_q_op            (q_op),
        .o_q_pop           (q_pop),
        .o_stat            (back_stat),
        .o_result_valid    (o_result_valid),
        .o_cursor_col      (o_cursor_col),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_location (o_cursor_location),
        .o_cell_value      (o_cell_value)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_ram.sv -----
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_front.sv -----
`default_nettype none

module tcw_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request channel
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [tcw_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  wire logic [tcw_pkg::ADDR_W-1:0]  i_cell_index,
    // register port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    // to queue / back
    input  wire logic                        i_q_full,
    input  wire tcw_pkg::t_back_stat         i_back_stat,
    output logic                             o_push,
    output tcw_pkg::t_op                     o_op,
    output logic      [tcw_pkg::ATTR_W-1:0]  o_attr
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] r_attr;
    logic              cfg_wr;

    // Attribute register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2:2] == REG_TEXT_ATTR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (cfg_wr) begin
            r_attr <= pwdata[ATTR_W-1:0];
        end
    end

    assign prdata = (paddr[2:2] == REG_TEXT_ATTR) ? {24'd0, r_attr} : 32'd0;
    assign o_attr = r_attr;

    // Hold off requests while the queue is full or the power-up sweep runs
    assign busy   = i_q_full | i_back_stat.sweeping;
    assign o_push = start & ~busy;

    // Classify the request
    always_comb begin
        o_op.kind       = OP_NOP;
        o_op.char_code  = i_char_code;
        o_op.cell_index = i_cell_index;
        case (i_mode)
            MODE_PUT: begin
                case (i_char_code)
                    CH_BS:   o_op.kind = OP_BS;
                    CH_TAB:  o_op.kind = OP_TAB;
                    CH_CR:   o_op.kind = OP_CR;
                    CH_LF:   o_op.kind = OP_LF;
                    default: begin
                        // printable range is 0x20..0x7F
                        if (!i_char_code[7] && (i_char_code[6:5] != 2'b00)) begin
                            o_op.kind = OP_PRINT;
                        end
                    end
                endcase
            end
            MODE_CLEAR: o_op.kind = OP_CLEAR;
            MODE_READ: begin
                // out-of-range reads return zero, same as a no-op
                if (i_cell_index < ADDR_W'(CELLS)) begin
                    o_op.kind = OP_READ;
                end
            end
            default: o_op.kind = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_queue.sv -----
`default_nettype none

module tcw_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire tcw_pkg::t_op i_op,
    input  wire logic         i_pop,
    output logic              o_valid,
    output tcw_pkg::t_op      o_op,
    output logic              o_full
);
    import tcw_pkg::*;

    t_op        r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    // Two-entry FIFO of classified operations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_op;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_op    = r_slot[r_rp];

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_back.sv -----
`default_nettype none

module tcw_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [tcw_pkg::ATTR_W-1:0]  i_attr,
    // queue side
    input  wire logic                        i_q_valid,
    input  wire tcw_pkg::t_op                i_q_op,
    output logic                             o_q_pop,
    output tcw_pkg::t_back_stat              o_stat,
    // result
    output logic                             o_result_valid,
    output logic      [tcw_pkg::COL_W-1:0]   o_cursor_col,
    output logic      [tcw_pkg::ROW_W-1:0]   o_cursor_row,
    output logic      [tcw_pkg::ADDR_W-1:0]  o_cursor_location,
    output logic      [tcw_pkg::CELL_W-1:0]  o_cell_value
);
    import tcw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_FILL
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_ptr, n_ptr;
    logic                r_pend, n_pend;
    logic [CELL_W-1:0]   r_fill_val, n_fill_val;
    logic                r_report, n_report;
    logic                r_sweep, n_sweep;
    logic [COL_W-1:0]    r_cx, n_cx;
    logic [ROW_W-1:0]    r_cy, n_cy;
    logic                r_res_valid, n_res_valid;
    logic [COL_W-1:0]    r_res_col, n_res_col;
    logic [ROW_W-1:0]    r_res_row, n_res_row;
    logic [ADDR_W-1:0]   r_res_loc, n_res_loc;
    logic [CELL_W-1:0]   r_res_val, n_res_val;

    logic                emit;
    logic [CELL_W-1:0]   emit_val;
    logic [COL_W:0]      x_next;
    logic [ROW_W:0]      y_next;
    logic                cursor_op;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Cursor motion for put-character ops, including wrap
    always_comb begin
        x_next    = {1'b0, r_cx};
        y_next    = {1'b0, r_cy};
        cursor_op = 1'b1;
        case (i_q_op.kind)
            OP_PRINT: x_next = {1'b0, r_cx} + (COL_W+1)'(1);
            OP_BS: begin
                if (r_cx != '0) begin
                    x_next = {1'b0, r_cx} - (COL_W+1)'(1);
                end
            end
            OP_TAB: x_next = ({1'b0, r_cx} + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
            OP_CR:  x_next = '0;
            OP_LF: begin
                x_next = '0;
                y_next = {1'b0, r_cy} + (ROW_W+1)'(1);
            end
            OP_NOP:  cursor_op = 1'b1;
            default: cursor_op = 1'b0;
        endcase
        if (x_next >= (COL_W+1)'(COLUMNS)) begin
            x_next = '0;
            y_next = y_next + (ROW_W+1)'(1);
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_pend      = 1'b0;
        n_fill_val  = r_fill_val;
        n_report    = r_report;
        n_sweep     = r_sweep;
        n_cx        = r_cx;
        n_cy        = r_cy;
        emit        = 1'b0;
        emit_val    = '0;
        ram_we      = 1'b0;
        ram_waddr   = cell_loc(r_cy, r_cx);
        ram_wdata   = {i_attr, i_q_op.char_code};
        ram_re      = 1'b0;
        ram_raddr   = i_q_op.cell_index;
        o_q_pop     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_op.kind == OP_CLEAR) begin
                        n_state    = S_FILL;
                        n_ptr      = '0;
                        n_fill_val = {i_attr, CH_SPACE};
                        n_report   = 1'b1;
                    end else if (i_q_op.kind == OP_READ) begin
                        ram_re  = 1'b1;
                        n_state = S_READ;
                    end else if (cursor_op) begin
                        ram_we = (i_q_op.kind == OP_PRINT);
                        n_cx   = x_next[COL_W-1:0];
                        if (y_next == (ROW_W+1)'(ROWS)) begin
                            // past the bottom line: scroll first
                            n_cy    = ROW_W'(ROWS - 1);
                            n_state = S_SCROLL;
                            n_ptr   = CNT_W'(COLUMNS);
                        end else begin
                            n_cy = y_next[ROW_W-1:0];
                            emit = 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                emit     = 1'b1;
                emit_val = ram_rdata;
                n_state  = S_IDLE;
            end
            S_SCROLL: begin
                // read one line ahead, write the word read last cycle
                ram_we    = r_pend;
                ram_waddr = ADDR_W'(r_ptr - CNT_W'(COLUMNS + 1));
                ram_wdata = ram_rdata;
                if (r_ptr != CNT_W'(CELLS)) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ptr[ADDR_W-1:0];
                    n_ptr     = r_ptr + CNT_W'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_state    = S_FILL;
                    n_ptr      = CNT_W'(CELLS - COLUMNS);
                    n_fill_val = {i_attr, CH_SPACE};
                    n_report   = 1'b1;
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[ADDR_W-1:0];
                ram_wdata = r_fill_val;
                if (r_ptr == CNT_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                    n_sweep = 1'b0;
                    emit    = r_report;
                end else begin
                    n_ptr = r_ptr + CNT_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Result register
        n_res_valid = emit;
        n_res_col   = r_res_col;
        n_res_row   = r_res_row;
        n_res_loc   = r_res_loc;
        n_res_val   = r_res_val;
        if (emit) begin
            n_res_col = n_cx;
            n_res_row = n_cy;
            n_res_loc = cell_loc(n_cy, n_cx);
            n_res_val = emit_val;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_fill_val  <= BLANK_RESET;
            r_report    <= 1'b0;
            r_sweep     <= 1'b1;
            r_cx        <= '0;
            r_cy        <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_pend      <= n_pend;
            r_fill_val  <= n_fill_val;
            r_report    <= n_report;
            r_sweep     <= n_sweep;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_res_valid <= n_res_valid;
        end
        r_res_col <= n_res_col;
        r_res_row <= n_res_row;
        r_res_loc <= n_res_loc;
        r_res_val <= n_res_val;
    end

    assign o_stat.sweeping   = r_sweep;
    assign o_result_valid    = r_res_valid;
    assign o_cursor_col      = r_res_col;
    assign o_cursor_row      = r_res_row;
    assign o_cursor_location = r_res_loc;
    assign o_cell_value      = r_res_val;

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_checker.sv -----
`default_nettype none

module tcw_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic                        o_result_valid,
    input  wire logic [tcw_pkg::COL_W-1:0]   o_cursor_col,
    input  wire logic [tcw_pkg::ROW_W-1:0]   o_cursor_row,
    input  wire logic [tcw_pkg::ADDR_W-1:0]  o_cursor_location
);
    import tcw_pkg::*;

    logic [ADDR_W-1:0] exp_loc;
    logic [2:0]        r_outstanding;

    assign exp_loc = cell_loc(o_cursor_row, o_cursor_col);

    // Requests taken minus results given (queue, engine and result stage hold at most four)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + 3'(start && !busy) - 3'(o_result_valid);
        end
    end

    // Power-up blanking holds off requests and gives no result
    ap_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_result_valid)
        else $error("busy low or result right after reset");

    // Reported cursor stays on the screen
    ap_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_cursor_col < COL_W'(COLUMNS))
                           && (o_cursor_row < ROW_W'(ROWS)))
        else $error("cursor off screen");

    // Location agrees with row and column
    ap_cursor_loc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_cursor_location == exp_loc))
        else $error("cursor location mismatch");

    // Every result answers a request that was taken earlier
    ap_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (r_outstanding != 3'd0))
        else $error("result with no request outstanding");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_result_valid    (o_result_valid),
    .o_cursor_col      (o_cursor_col),
    .o_cursor_row      (o_cursor_row),
    .o_cursor_location (o_cursor_location)
);

`default_nettype wire
